[hdl/sdrc_pkg.sv]
// Shared types and constants of the sliding door ramp controller.
// Used by the sequencer, the datapath, the top level and the checker.
`default_nettype none

package sdrc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned TIMER_W   = 17;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = 4;
  localparam int unsigned S_DATA_W  = 8;
  localparam int unsigned M_DATA_W  = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic               FUNC_TICK = 1'b0;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_RAMP_UP   = 3'd1,
    CFG_RAMP_DOWN = 3'd2,
    CFG_TOTAL     = 3'd3,
    CFG_MAX_SPEED = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_OPEN         = 3'd0,
    CMD_CLOSE        = 3'd1,
    CMD_STOP         = 3'd2,
    CMD_PUZZLE_RESET = 3'd3,
    CMD_STATUS       = 3'd4
  } door_cmd_e;

  typedef enum logic [2:0] {
    MODE_CLOSED  = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_OPENING = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_STOPPED = 3'd4
  } door_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_HIT   = 2'd1,
    EV_CLEAR = 2'd2
  } limit_ev_e;

  typedef enum logic [2:0] {
    NOTE_NONE             = 3'd0,
    NOTE_ALREADY_OPEN     = 3'd1,
    NOTE_ALREADY_OPENING  = 3'd2,
    NOTE_ALREADY_CLOSED   = 3'd3,
    NOTE_ALREADY_CLOSING  = 3'd4,
    NOTE_AT_LIMIT         = 3'd5,
    NOTE_TIMEOUT          = 3'd6
  } notice_e;

  typedef enum logic [1:0] {
    RAMP_RISE = 2'd0,
    RAMP_HOLD = 2'd1,
    RAMP_FALL = 2'd2
  } ramp_e;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_EVAL = 3'd1,
    SEQ_PREP = 3'd2,
    SEQ_MUL  = 3'd3,
    SEQ_DIV  = 3'd4,
    SEQ_FIN  = 3'd5,
    SEQ_DONE = 3'd6
  } seq_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic prep;
    logic mul;
    logic div_step;
    logic fin;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_ramp;
  } dp_sts_t;

  typedef struct packed {
    notice_e              notice;
    limit_ev_e            closed_event;
    limit_ev_e            open_event;
    logic                 lim_closed;
    logic                 lim_open;
    logic [DRIVE_W-1:0]   close_drive;
    logic [DRIVE_W-1:0]   open_drive;
    door_e                door_state;
  } res_t;

endpackage

`default_nettype wire

[hdl/sdrc_ctrl.sv]
// Sequencer of the sliding door ramp controller: steps one request through
// evaluate, ramp multiply, 16-step divide and result hand-off. Uses sdrc_pkg.
`default_nettype none

module sdrc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_free_i,
  input  wire sdrc_pkg::dp_sts_t    sts_i,
  output sdrc_pkg::ctrl_cmd_t       cmd_o,
  output logic                      in_ready_o
);

  sdrc_pkg::seq_state_e                 state_q, state_d;
  logic [sdrc_pkg::DIV_CNT_W-1:0]       cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdrc_pkg::SEQ_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sdrc_pkg::SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sdrc_pkg::SEQ_EVAL;
        end
      end
      sdrc_pkg::SEQ_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_ramp ? sdrc_pkg::SEQ_PREP : sdrc_pkg::SEQ_DONE;
      end
      sdrc_pkg::SEQ_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sdrc_pkg::SEQ_MUL;
      end
      sdrc_pkg::SEQ_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = sdrc_pkg::SEQ_DIV;
      end
      sdrc_pkg::SEQ_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == sdrc_pkg::DIV_CNT_W'(sdrc_pkg::DIV_STEPS - 1)) begin
          state_d = sdrc_pkg::SEQ_FIN;
        end
      end
      sdrc_pkg::SEQ_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = sdrc_pkg::SEQ_DONE;
      end
      sdrc_pkg::SEQ_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = sdrc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = sdrc_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/sdrc_dp.sv]
// Datapath of the sliding door ramp controller: registers, debounce, door
// mode update, ramp multiplier and restoring divider. Uses sdrc_pkg.
`default_nettype none

module sdrc_dp #(
  parameter int unsigned PWM_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sdrc_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [sdrc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_func_i,
  input  wire logic [sdrc_pkg::S_DATA_W-1:0] in_data_i,
  input  wire sdrc_pkg::ctrl_cmd_t           cmd_i,
  output sdrc_pkg::dp_sts_t                  sts_o,
  output sdrc_pkg::res_t                     res_o
);

  localparam int unsigned W  = sdrc_pkg::CFG_W;
  localparam int unsigned TW = sdrc_pkg::TIMER_W;
  localparam logic [W-1:0] PwmTop = W'((32'd1 << PWM_BITS) - 32'd1);

  // configuration
  logic [W-1:0] deb_ticks_q, up_ticks_q, down_ticks_q, total_q, max_q;

  // latched request
  logic       in_func_q;
  logic [2:0] in_cmd_q;
  logic [1:0] in_raw_q;  // bit0 open, bit1 closed

  // door state
  sdrc_pkg::door_e           mode_q, mode_n;
  logic [TW-1:0]             timer_q, timer_n, timer_inc;
  logic [1:0]                last_q, last_n, deb_q, deb_n;
  logic [W-1:0]              cnt_q [2];
  logic [W-1:0]              cnt_n [2];
  logic [W-1:0]              cnt_inc [2];
  logic [PWM_BITS-1:0]       drive_q [2];
  sdrc_pkg::limit_ev_e       ev_q [2];
  sdrc_pkg::limit_ev_e       ev_n [2];
  sdrc_pkg::notice_e         notice_q, notice_n;
  logic                      halt;
  logic                      need_ramp;

  // ramp arithmetic
  sdrc_pkg::ramp_e kind_q, kind_d;
  logic [W-1:0]    a_q, a_d, div_q, div_d;
  logic [W-1:0]    rem_q, lo_q;
  logic [W-1:0]    down, hold;
  logic [W:0]      trial;
  logic [W-1:0]    duty, duty_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= W'(50);
      up_ticks_q   <= W'(500);
      down_ticks_q <= W'(500);
      total_q      <= W'(5000);
      max_q        <= W'(255);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sdrc_pkg::CFG_DEBOUNCE:  deb_ticks_q  <= cfg_wdata_i;
        sdrc_pkg::CFG_RAMP_UP:   up_ticks_q   <= cfg_wdata_i;
        sdrc_pkg::CFG_RAMP_DOWN: down_ticks_q <= cfg_wdata_i;
        sdrc_pkg::CFG_TOTAL:     total_q      <= cfg_wdata_i;
        sdrc_pkg::CFG_MAX_SPEED: max_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_func_q <= in_func_i;
      in_cmd_q  <= in_data_i[2:0];
      in_raw_q  <= {in_data_i[4], in_data_i[3]};
    end
  end

  assign timer_inc = (timer_q == sdrc_pkg::TIMER_MAX) ? timer_q : timer_q + 1'b1;

  always_comb begin
    mode_n    = mode_q;
    timer_n   = timer_q;
    last_n    = last_q;
    deb_n     = deb_q;
    notice_n  = sdrc_pkg::NOTE_NONE;
    halt      = 1'b0;
    need_ramp = 1'b0;
    for (int sw = 0; sw < 2; sw++) begin
      cnt_n[sw]   = cnt_q[sw];
      cnt_inc[sw] = (cnt_q[sw] == sdrc_pkg::COUNT_MAX) ? cnt_q[sw] : cnt_q[sw] + 1'b1;
      ev_n[sw]    = sdrc_pkg::EV_NONE;
    end
    if (in_func_q == sdrc_pkg::FUNC_TICK) begin
      for (int sw = 0; sw < 2; sw++) begin
        if (in_raw_q[sw] != last_q[sw]) begin
          last_n[sw] = in_raw_q[sw];
          cnt_n[sw]  = '0;
        end else begin
          cnt_n[sw] = cnt_inc[sw];
          if (in_raw_q[sw] != deb_q[sw] && cnt_inc[sw] >= deb_ticks_q) begin
            deb_n[sw] = in_raw_q[sw];
            ev_n[sw]  = in_raw_q[sw] ? sdrc_pkg::EV_HIT : sdrc_pkg::EV_CLEAR;
          end
        end
      end
      if (mode_n == sdrc_pkg::MODE_OPENING && deb_n[0]) begin
        halt   = 1'b1;
        mode_n = sdrc_pkg::MODE_OPEN;
      end
      if (mode_n == sdrc_pkg::MODE_CLOSING && deb_n[1]) begin
        halt   = 1'b1;
        mode_n = sdrc_pkg::MODE_CLOSED;
      end
      if (mode_n == sdrc_pkg::MODE_OPENING || mode_n == sdrc_pkg::MODE_CLOSING) begin
        timer_n = timer_inc;
        if (timer_inc >= TW'(total_q) && timer_inc >= TW'(up_ticks_q)) begin
          halt     = 1'b1;
          mode_n   = (mode_n == sdrc_pkg::MODE_OPENING) ? sdrc_pkg::MODE_OPEN
                                                         : sdrc_pkg::MODE_CLOSED;
          notice_n = sdrc_pkg::NOTE_TIMEOUT;
        end else begin
          need_ramp = 1'b1;
        end
      end
    end else begin
      case (in_cmd_q)
        sdrc_pkg::CMD_OPEN: begin
          if (mode_q == sdrc_pkg::MODE_OPEN) begin
            notice_n = sdrc_pkg::NOTE_ALREADY_OPEN;
          end else if (mode_q == sdrc_pkg::MODE_OPENING) begin
            notice_n = sdrc_pkg::NOTE_ALREADY_OPENING;
          end else if (deb_q[0]) begin
            mode_n   = sdrc_pkg::MODE_OPEN;
            halt     = 1'b1;
            notice_n = sdrc_pkg::NOTE_AT_LIMIT;
          end else begin
            mode_n  = sdrc_pkg::MODE_OPENING;
            timer_n = '0;
            halt    = 1'b1;
          end
        end
        sdrc_pkg::CMD_CLOSE: begin
          if (mode_q == sdrc_pkg::MODE_CLOSED) begin
            notice_n = sdrc_pkg::NOTE_ALREADY_CLOSED;
          end else if (mode_q == sdrc_pkg::MODE_CLOSING) begin
            notice_n = sdrc_pkg::NOTE_ALREADY_CLOSING;
          end else if (deb_q[1]) begin
            mode_n   = sdrc_pkg::MODE_CLOSED;
            halt     = 1'b1;
            notice_n = sdrc_pkg::NOTE_AT_LIMIT;
          end else begin
            mode_n  = sdrc_pkg::MODE_CLOSING;
            timer_n = '0;
            halt    = 1'b1;
          end
        end
        sdrc_pkg::CMD_STOP: begin
          halt   = 1'b1;
          mode_n = sdrc_pkg::MODE_STOPPED;
        end
        sdrc_pkg::CMD_PUZZLE_RESET: begin
          halt   = 1'b1;
          mode_n = deb_q[1] ? sdrc_pkg::MODE_CLOSED :
                   (deb_q[0] ? sdrc_pkg::MODE_OPEN : sdrc_pkg::MODE_STOPPED);
        end
        default: ;  // status query and unused codes leave state alone
      endcase
    end
  end

  assign sts_o.need_ramp = need_ramp;

  // ramp segment select on the advanced timer
  always_comb begin
    down   = (down_ticks_q > total_q) ? total_q : down_ticks_q;
    hold   = total_q - down;
    kind_d = sdrc_pkg::RAMP_HOLD;
    a_d    = '0;
    div_d  = down;
    if (timer_q < TW'(up_ticks_q)) begin
      kind_d = sdrc_pkg::RAMP_RISE;
      a_d    = timer_q[W-1:0];
      div_d  = up_ticks_q;
    end else if (timer_q >= TW'(hold)) begin
      kind_d = sdrc_pkg::RAMP_FALL;
      a_d    = timer_q[W-1:0] - hold;
    end
  end

  assign trial = {rem_q, lo_q[W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      kind_q <= kind_d;
      a_q    <= a_d;
      div_q  <= div_d;
    end
    if (cmd_i.mul) begin
      {rem_q, lo_q} <= a_q * max_q;
    end else if (cmd_i.div_step) begin
      // quotient bits shift into the low half as dividend bits leave it
      if (trial >= {1'b0, div_q}) begin
        rem_q <= W'(trial - {1'b0, div_q});
        lo_q  <= {lo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        lo_q  <= {lo_q[W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (kind_q)
      sdrc_pkg::RAMP_RISE: duty = lo_q;
      sdrc_pkg::RAMP_FALL: duty = max_q - lo_q;
      default:             duty = max_q;
    endcase
    duty_sat = (duty > PwmTop) ? PwmTop : duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sdrc_pkg::MODE_STOPPED;
      timer_q    <= '0;
      last_q     <= '0;
      deb_q      <= '0;
      cnt_q[0]   <= '0;
      cnt_q[1]   <= '0;
      drive_q[0] <= '0;
      drive_q[1] <= '0;
      ev_q[0]    <= sdrc_pkg::EV_NONE;
      ev_q[1]    <= sdrc_pkg::EV_NONE;
      notice_q   <= sdrc_pkg::NOTE_NONE;
    end else if (cmd_i.eval) begin
      mode_q   <= mode_n;
      timer_q  <= timer_n;
      last_q   <= last_n;
      deb_q    <= deb_n;
      cnt_q[0] <= cnt_n[0];
      cnt_q[1] <= cnt_n[1];
      ev_q[0]  <= ev_n[0];
      ev_q[1]  <= ev_n[1];
      notice_q <= notice_n;
      if (halt) begin
        drive_q[0] <= '0;
        drive_q[1] <= '0;
      end
    end else if (cmd_i.fin) begin
      drive_q[0] <= (mode_q == sdrc_pkg::MODE_OPENING) ? duty_sat[PWM_BITS-1:0] : '0;
      drive_q[1] <= (mode_q == sdrc_pkg::MODE_CLOSING) ? duty_sat[PWM_BITS-1:0] : '0;
    end
  end

  assign res_o.door_state   = mode_q;
  assign res_o.open_drive   = sdrc_pkg::DRIVE_W'(drive_q[0]);
  assign res_o.close_drive  = sdrc_pkg::DRIVE_W'(drive_q[1]);
  assign res_o.lim_open     = deb_q[0];
  assign res_o.lim_closed   = deb_q[1];
  assign res_o.open_event   = ev_q[0];
  assign res_o.closed_event = ev_q[1];
  assign res_o.notice       = notice_q;

endmodule

`default_nettype wire

[hdl/sliding_door_ramp_controller_top.sv]
// Top level of the sliding door ramp controller: sequencer, datapath and
// the output register. Depends on sdrc_pkg, sdrc_ctrl and sdrc_dp.
//
// Usage:
//   Input stream: tuser carries func (0 tick with limit sample, 1 command);
//   tdata carries the command code and the raw open and closed limit levels.
//   Output stream: one result per request with door state, both PWM duties,
//   debounced limits, limit events and a notice code.
//   Configuration: write cfg_wdata_i to register cfg_addr_i while cfg_we_i
//   is high; write only while no request is in flight.
//   Timing: a command, or a tick while the door rests, goes from evaluation
//   straight to result hand-off; a tick that leaves the door moving also
//   runs the ramp multiply, the 16-step restoring divider of the ramp
//   interpolation and a finish step. One request is in work at a time; the
//   next is taken after the current result enters the output register.
//   Stall: the result waits in the output register; the next request can be
//   accepted and worked while it waits, and finishes once the register frees.
//   Reset: door stopped, limits clear, drives off, config at default values.
`default_nettype none

module sliding_door_ramp_controller_top #(
  parameter int unsigned PWM_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sdrc_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [sdrc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: command[2:0], raw_open[3], raw_closed[4], zero fill
  input  wire logic [sdrc_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // tuser: func[0]
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: door_state[2:0], open_drive[18:3], close_drive[34:19],
  // lim_open[35], lim_closed[36], open_event[38:37],
  // closed_event[40:39], notice[43:41], zero fill
  output logic [sdrc_pkg::M_DATA_W-1:0]      m_axis_tdata_o
);

  sdrc_pkg::ctrl_cmd_t              cmd;
  sdrc_pkg::dp_sts_t                sts;
  sdrc_pkg::res_t                   res;
  logic                             out_free;
  logic                             m_valid_q;
  logic [sdrc_pkg::M_DATA_W-1:0]    m_data_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  sdrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o)
  );

  sdrc_dp #(
    .PWM_BITS (PWM_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      m_data_q <= sdrc_pkg::M_DATA_W'(res);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

[hdl/sdrc_checker.sv]
// Port-level checker of the sliding door ramp controller, bound to the top
// level. Depends on sdrc_pkg for the door state codes.
`default_nettype none

module sdrc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [sdrc_pkg::M_DATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in work");

  a_open_drive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] != 3'(sdrc_pkg::MODE_OPENING))
    |-> m_axis_tdata_o[18:3] == 16'd0)
    else $error("open drive active while not opening");

  a_close_drive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] != 3'(sdrc_pkg::MODE_CLOSING))
    |-> m_axis_tdata_o[34:19] == 16'd0)
    else $error("close drive active while not closing");

endmodule

bind sliding_door_ramp_controller_top sdrc_checker u_sdrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
